### rtl/fnmf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the four-neighbor max filter.
// No dependencies; imported by the top level and by the checker.
package fnmf_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int PIXEL_BITS = 32;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CFG_W = 11;
    localparam int IDX_W = 1;

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;
    typedef logic [PIXEL_BITS-2:0]        nmax_t;
    typedef logic [COL_W-1:0]             col_t;
    typedef logic [ROW_W-1:0]             row_t;
    typedef logic [CFG_W-1:0]             cfg_t;
    typedef logic [IDX_W-1:0]             reg_idx_t;

    localparam reg_idx_t REG_ROW_COUNT = 1'b0;
    localparam reg_idx_t REG_COL_COUNT = 1'b1;

    // Last valid column index: zero acts as one column, oversize acts as the maximum.
    function automatic col_t last_col_index(cfg_t v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_COLS) begin
            return col_t'(MAX_COLS - 1);
        end
        return col_t'(v - cfg_t'(1));
    endfunction

    function automatic row_t last_row_index(cfg_t v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_ROWS) begin
            return row_t'(MAX_ROWS - 1);
        end
        return row_t'(v - cfg_t'(1));
    endfunction

    // Largest of the enabled candidates, floored at zero.
    function automatic nmax_t floor_max4(pixel_t a, pixel_t b, pixel_t c, pixel_t d,
                                         logic [3:0] en);
        pixel_t best;
        best = '0;
        if (en[0] && a > best) best = a;
        if (en[1] && b > best) best = b;
        if (en[2] && c > best) best = c;
        if (en[3] && d > best) best = d;
        return best[PIXEL_BITS-2:0];
    endfunction

endpackage

### rtl/four_neighbor_max_filter.sv
`timescale 1ns / 1ps
// Four-neighbor max filter top level: raster pixel input, tagged result output.
// Depends on fnmf_pkg and fnmf_ram (two line buffers).
//
// Usage:
//   Pixels enter on s_valid/s_ready in raster order, one frame of row_count x
//   col_count at a time. Each result gives the largest of the up, down, left and
//   right neighbors of one position (zero if all are negative or none exist),
//   tagged with its row, column and a frame-end mark, on m_valid/m_ready.
//   A position in an upper row is reported when the pixel below it arrives; on the
//   last row a position is reported when the pixel to its right arrives, and the
//   final pixel also reports its own position with m_frame_end high.
//   A released result passes through the compute stage and the output register.
//   Throughput: one pixel per cycle on every row but the last while m_ready is high.
//   On the last row a pixel past column 0 releases up to two results and the final
//   pixel up to three; the single result stage delivers one result per cycle while
//   m_ready is high, so those pixels hold s_ready low until their last result goes.
//   The line buffers are two RAMs that swap roles at each row end; each RAM takes
//   one read and one write per cycle.
//   Writing row_count or col_count (only while idle) restarts at row 0, column 0.
//   Reset sets row_count to 4, col_count to 5 and clears all handshake state; the
//   line buffers are not cleared and need no clearing pass.
//   When m_ready is low, one result waits in the output register and the next
//   pixel's results wait in the compute stage; s_ready then drops.
module four_neighbor_max_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  fnmf_pkg::reg_idx_t cfg_index,
    input  fnmf_pkg::cfg_t     cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  fnmf_pkg::pixel_t   s_pixel,
    output logic               m_valid,
    input  logic               m_ready,
    output fnmf_pkg::nmax_t    m_neighbor_max,
    output fnmf_pkg::row_t     m_out_row,
    output fnmf_pkg::col_t     m_out_col,
    output logic               m_frame_end
);
    import fnmf_pkg::*;

    // Bit positions in the pending-result mask, in delivery order.
    localparam int PEND_UP   = 0;
    localparam int PEND_LEFT = 1;
    localparam int PEND_SELF = 2;

    typedef struct packed {
        logic up1;       // row >= 1
        logic up2;       // row >= 2
        logic has_right; // column + 1 < col_count
        logic col0;      // column == 0
        logic col_ge1;
        logic col_ge2;
    } s1_ctl_t;

    // Configuration and position state
    cfg_t   row_count_reg;
    cfg_t   col_count_reg;
    row_t   row_pos_reg;
    col_t   col_pos_reg;
    logic   bank_reg;        // 0: RAM A holds older row, RAM B previous row
    pixel_t row0_cur_reg;    // column 0 of the row now arriving
    pixel_t prev0_reg;       // column 0 of the previous row

    // Compute stage
    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic [2:0] s1_pend_reg;
    logic [2:0] s1_pend_next;
    s1_ctl_t  s1_ctl_reg;
    pixel_t   s1_pix_reg;
    pixel_t   s1_prev0_reg;
    row_t     s1_row_reg;
    col_t     s1_col_reg;
    logic     s1_bank_reg;

    // Sliding windows over the previous row and the current row
    pixel_t win_m1_reg;
    pixel_t win0_reg;
    pixel_t cur_m1_reg;
    pixel_t cur_m2_reg;

    // Output register
    logic   m_valid_reg;
    nmax_t  m_max_reg;
    row_t   m_row_reg;
    col_t   m_col_reg;
    logic   m_end_reg;

    // Stage 0 signals
    row_t   last_row;
    col_t   last_col;
    logic   in_range;
    row_t   cur_row;
    col_t   cur_col;
    col_t   col_plus1;
    logic   accept;
    logic   at_row_end;
    logic   at_last_row;
    logic [2:0] load_pend;
    s1_ctl_t load_ctl;

    // RAM ports
    logic   a_wr_en;
    logic   b_wr_en;
    col_t   a_rd_addr;
    col_t   b_rd_addr;
    pixel_t a_q;
    pixel_t b_q;

    // Stage 1 signals
    pixel_t older_q;
    pixel_t prev_q;
    pixel_t pm1;
    pixel_t p0;
    nmax_t  res_up;
    nmax_t  res_left;
    nmax_t  res_self;
    logic   out_free;
    logic   emit;
    logic [2:0] pend_clr;
    logic [2:0] pend_after;
    logic   s1_done;
    nmax_t  sel_max;
    row_t   sel_row;
    col_t   sel_col;
    logic   sel_end;

    // ---------------- Stage 0: position tracking and line buffer access ----------------

    assign last_row  = last_row_index(row_count_reg);
    assign last_col  = last_col_index(col_count_reg);
    assign in_range  = (row_pos_reg <= last_row) && (col_pos_reg <= last_col);
    assign cur_row   = in_range ? row_pos_reg : '0;
    assign cur_col   = in_range ? col_pos_reg : '0;
    assign col_plus1 = cur_col + col_t'(1);

    assign accept      = s_valid && s_ready;
    assign at_row_end  = (cur_col == last_col);
    assign at_last_row = (cur_row == last_row);

    always_comb begin
        load_pend            = '0;
        load_pend[PEND_UP]   = (cur_row != '0);
        load_pend[PEND_LEFT] = at_last_row && (cur_col != '0);
        load_pend[PEND_SELF] = at_last_row && at_row_end;

        load_ctl.up1       = (cur_row != '0);
        load_ctl.up2       = (cur_row > row_t'(1));
        load_ctl.has_right = !at_row_end;
        load_ctl.col0      = (cur_col == '0);
        load_ctl.col_ge1   = (cur_col != '0);
        load_ctl.col_ge2   = (cur_col > col_t'(1));
    end

    // Older-row bank reads column c (old contents) and takes the arriving pixel;
    // previous-row bank reads column c + 1.
    assign a_wr_en   = accept && !bank_reg;
    assign b_wr_en   = accept && bank_reg;
    assign a_rd_addr = bank_reg ? col_plus1 : cur_col;
    assign b_rd_addr = bank_reg ? cur_col : col_plus1;

    fnmf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (cur_col),
        .wr_data (s_pixel),
        .rd_en   (accept),
        .rd_addr (a_rd_addr),
        .rd_data (a_q)
    );

    fnmf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (cur_col),
        .wr_data (s_pixel),
        .rd_en   (accept),
        .rd_addr (b_rd_addr),
        .rd_data (b_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= cfg_t'(4);
            col_count_reg <= cfg_t'(5);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            bank_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            // Any register write restarts the frame
            if (cfg_index == REG_ROW_COUNT) begin
                row_count_reg <= cfg_wdata;
            end
            if (cfg_index == REG_COL_COUNT) begin
                col_count_reg <= cfg_wdata;
            end
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else if (accept) begin
            if (at_row_end) begin
                // Swap bank roles and advance to the next row
                col_pos_reg <= '0;
                bank_reg    <= !bank_reg;
                row_pos_reg <= at_last_row ? '0 : cur_row + row_t'(1);
            end else begin
                col_pos_reg <= col_plus1;
                row_pos_reg <= cur_row;
            end
        end
    end

    // Column 0 of each row is kept aside, since the first pixel of a row needs
    // both column 0 and column 1 of the row above in the same cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (load_ctl.col0) begin
                row0_cur_reg <= s_pixel;
            end
            if (at_row_end) begin
                prev0_reg <= load_ctl.col0 ? s_pixel : row0_cur_reg;
            end
        end
    end

    // ---------------- Stage 1: neighbor maxima and result sequencing ----------------

    assign older_q = s1_bank_reg ? b_q : a_q;
    assign prev_q  = s1_bank_reg ? a_q : b_q;
    assign pm1     = win_m1_reg;
    assign p0      = s1_ctl_reg.col0 ? s1_prev0_reg : win0_reg;

    // Upper row position: older above, arriving pixel below, previous row left/right
    assign res_up   = floor_max4(older_q, s1_pix_reg, pm1, prev_q,
                                 {s1_ctl_reg.has_right, s1_ctl_reg.col_ge1, 1'b1,
                                  s1_ctl_reg.up2});
    // Last row, column to the left: above, its left, arriving pixel on its right
    assign res_left = floor_max4(pm1, cur_m2_reg, s1_pix_reg, '0,
                                 {1'b0, 1'b1, s1_ctl_reg.col_ge2, s1_ctl_reg.up1});
    // Final position: above and left only
    assign res_self = floor_max4(p0, cur_m1_reg, '0, '0,
                                 {2'b00, s1_ctl_reg.col_ge1, s1_ctl_reg.up1});

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = s1_valid_reg && (s1_pend_reg != '0) && out_free;

    always_comb begin
        pend_clr = '0;
        sel_max  = res_self;
        sel_row  = s1_row_reg;
        sel_col  = s1_col_reg;
        sel_end  = 1'b1;
        priority if (s1_pend_reg[PEND_UP]) begin
            pend_clr[PEND_UP] = 1'b1;
            sel_max = res_up;
            sel_row = s1_row_reg - row_t'(1);
            sel_end = 1'b0;
        end else if (s1_pend_reg[PEND_LEFT]) begin
            pend_clr[PEND_LEFT] = 1'b1;
            sel_max = res_left;
            sel_col = s1_col_reg - col_t'(1);
            sel_end = 1'b0;
        end else begin
            pend_clr[PEND_SELF] = 1'b1;
        end
    end

    assign pend_after = emit ? (s1_pend_reg & ~pend_clr) : s1_pend_reg;
    assign s1_done    = s1_valid_reg && (pend_after == '0);
    assign s_ready    = !s1_valid_reg || s1_done;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_pend_next  = pend_after;
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_pend_next  = load_pend;
        end else if (s1_done) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s1_pend_reg  <= s1_pend_next;
        end
    end

    // Hold the item's payload; the RAM outputs hold as well until the next accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg   <= load_ctl;
            s1_pix_reg   <= s_pixel;
            s1_prev0_reg <= prev0_reg;
            s1_row_reg   <= cur_row;
            s1_col_reg   <= cur_col;
            s1_bank_reg  <= bank_reg;
        end
        if (s1_done) begin
            // Advance the windows by one column
            win_m1_reg <= p0;
            win0_reg   <= prev_q;
            cur_m2_reg <= cur_m1_reg;
            cur_m1_reg <= s1_pix_reg;
        end
    end

    // ---------------- Output register ----------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_max_reg <= sel_max;
            m_row_reg <= sel_row;
            m_col_reg <= sel_col;
            m_end_reg <= sel_end;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_neighbor_max = m_max_reg;
    assign m_out_row      = m_row_reg;
    assign m_out_col      = m_col_reg;
    assign m_frame_end    = m_end_reg;

endmodule

### rtl/fnmf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read-first on an address collision. No dependencies.
module fnmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/fnmf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the four-neighbor max filter, bound to the top level.
// Depends on fnmf_pkg.
module fnmf_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            cfg_wr_en,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input fnmf_pkg::nmax_t m_neighbor_max,
    input fnmf_pkg::row_t  m_out_row,
    input fnmf_pkg::col_t  m_out_col,
    input logic            m_frame_end
);
    import fnmf_pkg::*;

    // Set while the next result must be the first one of a frame.
    logic first_reg;
    logic first_next;

    always_comb begin
        first_next = first_reg;
        if (cfg_wr_en || (m_valid && m_ready && m_frame_end)) begin
            first_next = 1'b1;
        end else if (m_valid && m_ready) begin
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbor_max) &&
            $stable(m_out_row) && $stable(m_out_col) && $stable(m_frame_end))
        else $error("stalled result changed");

    a_frame_starts_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && first_reg |-> (m_out_row == '0) && (m_out_col == '0))
        else $error("frame does not start at row 0, column 0");

    a_stall_has_results: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid)
        else $error("input stalled with no result on its way");

endmodule

bind four_neighbor_max_filter fnmf_checker u_fnmf_checker (.*);
